@@ rtl/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

  localparam int unsigned KEY_W         = 32;
  localparam int unsigned PAYLOAD_W     = 32;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned ENTRY_TOTAL_W = 5;
  localparam int unsigned DEPTH_DEFAULT = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic                     ok;
    logic [KEY_W-1:0]         result_key;
    logic [PAYLOAD_W-1:0]     result_payload;
    logic [ENTRY_TOTAL_W-1:0] entry_total;
    logic                     is_empty;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the accepted item
    logic rd_head;   // read the head entry
    logic rd_prev;   // read the entry in front of the insert slot
    logic wr_new;    // write the new entry into the insert slot
    logic wr_shift;  // move the entry just read back one slot
    logic idx_dec;   // insert slot moves toward the head
    logic finish;    // load the output register, commit count and head
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_enq;
    logic is_head_op;
    logic full;
    logic empty;
    logic idx_zero;
    logic ahead;     // new key goes ahead of the entry just read
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
`default_nettype none

// channel | direction | handshake                    | item
// in      | input     | in_valid_i / in_stall_o      | in_i  (kind, key, payload)
// out     | output    | out_valid_o / out_stall_i    | out_o (ok, result_key, result_payload,
//         |           |                              |        entry_total, is_empty)
// cfg     | input     | cfg_we_i                     | cfg_wdata_i (order_mode)
//
// One item at a time. Dequeue and peek on a non-empty queue read the head entry;
// a refused enqueue, dequeue or peek when empty and the unused kind go straight to
// the finish step. Enqueue walks from the tail through the entry RAM (one read,
// compare, write per entry), moving back each entry that the new key goes ahead of.
// Reset empties the queue and clears order_mode; RAM contents are not cleared.
// A result waits in the output register under out_stall_i while the next item
// is accepted; that item finishes once the register is free.

module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire spq_pkg::in_item_t  in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output spq_pkg::out_item_t      out_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i
);

  import spq_pkg::*;

  cmd_t    cmd;
  status_t status;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

@@ rtl/spq_ram.sv @@
`default_nettype none

module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/spq_ctrl.sv @@
`default_nettype none

module spq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire spq_pkg::status_t status_i,
  output spq_pkg::cmd_t         cmd_o
);

  import spq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECODE   = 6'b000010,
    S_ENQ_STEP = 6'b000100,
    S_ENQ_CMP  = 6'b001000,
    S_HEAD_RD  = 6'b010000,
    S_FINISH   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.is_enq && !status_i.full) begin
          state_d = S_ENQ_STEP;
        end else if (status_i.is_head_op && !status_i.empty) begin
          state_d = S_HEAD_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_ENQ_STEP: begin
        if (status_i.idx_zero) begin
          cmd_o.wr_new = 1'b1;
          state_d      = S_FINISH;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_ENQ_CMP;
        end
      end
      S_ENQ_CMP: begin
        if (status_i.ahead) begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.idx_dec  = 1'b1;
          state_d        = S_ENQ_STEP;
        end else begin
          cmd_o.wr_new = 1'b1;
          state_d      = S_FINISH;
        end
      end
      S_HEAD_RD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/spq_dp.sv @@
`default_nettype none

module spq_dp #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spq_pkg::in_item_t  in_i,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire spq_pkg::cmd_t      cmd_i,
  output spq_pkg::status_t        status_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output spq_pkg::out_item_t      out_o
);

  import spq_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [AW:0]      DEPTH_SUM = (AW + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [AW-1:0]    ADDR_ONE  = AW'(1);

  // ring position of logical slot b counted from head a
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_SUM) begin
      s = s - DEPTH_SUM;
    end
    return s[AW-1:0];
  endfunction

  logic             mode_q;
  logic [AW-1:0]    head_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] idx_q;
  in_item_t         op_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [CNT_W-1:0] idx_m1;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           rd_entry;

  logic             is_enq, is_deq, is_peek;
  logic             full, empty;
  logic             out_free;
  logic             enq_ok, head_ok;
  logic [CNT_W-1:0] count_d;
  out_item_t        out_d;

  assign is_enq  = (op_q.kind == KIND_ENQ);
  assign is_deq  = (op_q.kind == KIND_DEQ);
  assign is_peek = (op_q.kind == KIND_PEEK);
  assign full    = (count_q == DEPTH_CNT);
  assign empty   = (count_q == '0);
  assign idx_m1  = idx_q - CNT_ONE;
  assign rd_entry = entry_t'(ram_rdata);
  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.is_enq     = is_enq;
  assign status_o.is_head_op = is_deq || is_peek;
  assign status_o.full       = full;
  assign status_o.empty      = empty;
  assign status_o.idx_zero   = (idx_q == '0);
  assign status_o.ahead      = mode_q ? (op_q.key > rd_entry.key)
                                      : (op_q.key < rd_entry.key);
  assign status_o.out_free   = out_free;

  assign ram_we    = cmd_i.wr_new || cmd_i.wr_shift;
  assign ram_waddr = ring_add(head_q, idx_q[AW-1:0]);
  assign ram_wdata = cmd_i.wr_shift ? rd_entry : entry_t'({op_q.key, op_q.payload});
  assign ram_re    = cmd_i.rd_head || cmd_i.rd_prev;
  assign ram_raddr = cmd_i.rd_head ? head_q : ring_add(head_q, idx_m1[AW-1:0]);

  spq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    enq_ok  = is_enq && !full;
    head_ok = (is_deq || is_peek) && !empty;
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CNT_ONE;
    end else if (is_deq && !empty) begin
      count_d = count_q - CNT_ONE;
    end
    out_d.ok             = enq_ok || head_ok;
    out_d.result_key     = head_ok ? rd_entry.key : '0;
    out_d.result_payload = head_ok ? rd_entry.payload : '0;
    out_d.entry_total    = ENTRY_TOTAL_W'(count_d);
    out_d.is_empty       = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        idx_q <= count_q;
      end else if (cmd_i.idx_dec) begin
        idx_q <= idx_m1;
      end
      if (cmd_i.finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
        if (is_deq && !empty) begin
          head_q <= ring_add(head_q, ADDR_ONE);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_i;
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_sorted_priority_queue.sv @@
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_o;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  sorted_priority_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow of the sorted store, head at index 0
  logic [KEY_W-1:0] held_keys[QUEUE_DEPTH];
  logic [PAYLOAD_W-1:0] held_payloads[QUEUE_DEPTH];
  int held_count = 0;
  logic serve_larger = 1'b0;

  in_item_t pending_ops[$];
  out_item_t due_results[$];
  out_item_t head_result;

  logic in_taken = 1'b0;
  logic quiet_mode = 1'b0;
  logic hold_done = 1'b0;
  int in_gap = 0;
  int stall_left = 0;
  int ops_accepted = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic goes_ahead(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    return serve_larger ? (a > b) : (a < b);
  endfunction

  function automatic out_item_t apply_queue_op(in_item_t op);
    out_item_t res;
    int slot;
    res = '0;
    case (op.kind)
      KIND_ENQ: begin
        if (held_count < QUEUE_DEPTH) begin
          // walk from the tail; equal keys stay ahead of the new entry
          slot = held_count;
          while (slot > 0 && goes_ahead(op.key, held_keys[slot-1])) begin
            held_keys[slot] = held_keys[slot-1];
            held_payloads[slot] = held_payloads[slot-1];
            slot--;
          end
          held_keys[slot] = op.key;
          held_payloads[slot] = op.payload;
          held_count++;
          res.ok = 1'b1;
        end
      end
      KIND_DEQ, KIND_PEEK: begin
        if (held_count > 0) begin
          res.ok = 1'b1;
          res.result_key = held_keys[0];
          res.result_payload = held_payloads[0];
          if (op.kind == KIND_DEQ) begin
            for (slot = 1; slot < held_count; slot++) begin
              held_keys[slot-1] = held_keys[slot];
              held_payloads[slot-1] = held_payloads[slot];
            end
            held_count--;
          end
        end
      end
      default: ;
    endcase
    res.entry_total = held_count[ENTRY_TOTAL_W-1:0];
    res.is_empty = (held_count == 0);
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function automatic void queue_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                   logic [PAYLOAD_W-1:0] payload);
    in_item_t op;
    op.kind = kind;
    op.key = key;
    op.payload = payload;
    pending_ops.push_back(op);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) return KEY_W'($urandom_range(0, 7));  // dense keys make ties
    if (r == 8) return '0;
    if (r == 9) return '1;
    return $urandom;
  endfunction

  task automatic queue_random_ops(int count);
    int enq_pct;
    int r;
    for (int n = 0; n < count; n++) begin
      // change the enqueue bias in runs so the queue swings between empty and full
      if (n % 40 == 0) begin
        r = $urandom_range(0, 2);
        enq_pct = (r == 0) ? 35 : (r == 1) ? 55 : 80;
      end
      if ($urandom_range(0, 99) < enq_pct) begin
        queue_op(KIND_ENQ, pick_key(), $urandom);
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0) queue_op(KIND_UNUSED, $urandom, $urandom);
        else if (r <= 5) queue_op(KIND_PEEK, $urandom, $urandom);
        else queue_op(KIND_DEQ, $urandom, $urandom);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_order(logic mode);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    serve_larger = mode;
    @(posedge clk_i);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 2);
        in_valid_i <= 1'b0;
      end else begin
        in_i <= pending_ops.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // receiver, with one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (!hold_done && ops_accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      due_results.push_back(apply_queue_op(in_i));
      ops_accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item, expected none, actual %p", $time, out_o);
      end else begin
        head_result = due_results.pop_front();
        check_field("ok", head_result.ok, out_o.ok);
        check_field("result_key", head_result.result_key, out_o.result_key);
        check_field("result_payload", head_result.result_payload, out_o.result_payload);
        check_field("entry_total", head_result.entry_total, out_o.entry_total);
        check_field("is_empty", head_result.is_empty, out_o.is_empty);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_order(1'b0);
    // empty queue, then extreme keys, ties, fill to full and drain a little
    queue_op(KIND_DEQ, $urandom, $urandom);
    queue_op(KIND_PEEK, $urandom, $urandom);
    queue_op(KIND_UNUSED, $urandom, $urandom);
    queue_op(KIND_ENQ, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_op(KIND_ENQ, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_op(KIND_ENQ, 32'd5, 32'h0000_000A);
    queue_op(KIND_ENQ, 32'd5, 32'h0000_000B);
    for (int n = 0; n < 12; n++) queue_op(KIND_ENQ, KEY_W'($urandom_range(4, 6)), $urandom);
    queue_op(KIND_ENQ, 32'd1, 32'h0000_1234);  // refused, queue full
    queue_op(KIND_UNUSED, $urandom, $urandom);
    queue_op(KIND_PEEK, $urandom, $urandom);
    repeat (3) queue_op(KIND_DEQ, $urandom, $urandom);
    wait_drained();

    set_order(1'b1);
    queue_random_ops(450);
    wait_drained();

    set_order(1'b0);
    queue_random_ops(450);
    wait_drained();

    set_order(1'b1);
    quiet_mode = 1'b1;
    queue_random_ops(475);
    wait_drained();
    repeat (50) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_ctrl.sv
rtl/spq_dp.sv
rtl/sorted_priority_queue.sv
tb/sv/tb_sorted_priority_queue.sv
